>>> design/wbd_pkg.sv
// Shared types and constants for the weighted block downsampler.
package wbd_pkg;
  localparam int MAX_EDGE = 32;
  localparam int MAX_FACTOR = 8;
  localparam int VALUE_BITS = 24;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_W = 15;
  localparam int ACC_W = 49;
  localparam int WACC_W = 25;
  localparam int VAL_W = 24;

  // configuration register indexes
  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_EDGE   = 2'd1;
  localparam logic [1:0] REG_MASS   = 2'd2;

  // front-to-back work item
  typedef struct packed {
    logic [ACC_W-1:0]  acc;
    logic [WACC_W-1:0] wacc;
    logic [IDX_W-1:0]  idx;
    logic              done;
  } job_t;
endpackage

>>> design/wbd_front.sv
// Front end: cell position tracking, group accumulation, result job issue.
module wbd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          restart,
  input  logic [3:0]                    factor,
  input  logic [5:0]                    block_edge,
  input  logic                          mass_weighting,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [wbd_pkg::VALUE_BITS-1:0] in_value,
  input  logic [wbd_pkg::WEIGHT_BITS-1:0]       in_density,
  output logic                          job_valid,
  input  logic                          job_ready,
  output wbd_pkg::job_t                 job
);
  localparam int MAX_EDGE = wbd_pkg::MAX_EDGE;
  localparam int MAX_FACTOR = wbd_pkg::MAX_FACTOR;
  localparam int VALUE_BITS = wbd_pkg::VALUE_BITS;
  localparam int WEIGHT_BITS = wbd_pkg::WEIGHT_BITS;
  localparam int PW = $clog2(MAX_EDGE + 1) + 1;
  localparam int DEPTH = MAX_EDGE * MAX_EDGE;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(MAX_FACTOR + 1) + 1;
  localparam int PRW = VALUE_BITS + WEIGHT_BITS + 1;

  // sequencer: IDLE -> RD (memory read) -> WR (accumulate, write, maybe issue)
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [PW-1:0] px_r, py_r, pz_r;
  logic [PW-1:0] gx_r, gy_r, gz_r;   // group coordinates
  logic [FW-1:0] sx_r, sy_r, sz_r;   // sub-position within group
  logic [AW-1:0] slot_r;
  logic [AW-1:0] row_base_r;         // gy*d
  logic [wbd_pkg::IDX_W-1:0] plane_base_r; // gz*d*d
  logic [wbd_pkg::IDX_W-1:0] idx_r;
  logic          first_r, last_r, done_r;
  logic signed [PRW-1:0] prod_r;
  logic [WEIGHT_BITS-1:0] w_r;

  logic signed [wbd_pkg::ACC_W-1:0] acc_mem [DEPTH];
  logic [wbd_pkg::WACC_W-1:0]       wacc_mem [DEPTH];
  logic signed [wbd_pkg::ACC_W-1:0] acc_rd_r;
  logic [wbd_pkg::WACC_W-1:0]       wacc_rd_r;

  logic [FW-1:0] f;
  logic [PW-1:0] e, d, span;
  always_comb begin
    f = (factor == 4'd0) ? FW'(1) : FW'(factor);
    if (f > FW'(MAX_FACTOR)) f = FW'(MAX_FACTOR);
    e = (block_edge == 6'd0) ? PW'(1) : PW'(block_edge);
    if (e > PW'(MAX_EDGE)) e = PW'(MAX_EDGE);
  end

  // d = edge/factor by repeated subtraction after reset or any cfg write
  logic [PW-1:0] d_r, span_r, rem_r;
  logic          calc_init_r, calc_run_r;
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      calc_init_r <= 1'b1;
      calc_run_r <= 1'b0;
    end else if (calc_init_r) begin
      calc_init_r <= 1'b0;
      calc_run_r <= 1'b1;
      rem_r <= e;
      d_r <= '0;
      span_r <= '0;
    end else if (calc_run_r) begin
      if (rem_r >= PW'(f)) begin
        rem_r <= rem_r - PW'(f);
        d_r <= d_r + 1'b1;
        span_r <= span_r + PW'(f);
      end else begin
        calc_run_r <= 1'b0;
      end
    end
  end
  assign d = d_r;
  assign span = span_r;

  logic active;
  assign active = (d != '0) && (px_r < span) && (py_r < span) && (pz_r < span);

  assign in_ready = (state_r == ST_IDLE) && !restart && !calc_init_r && !calc_run_r;

  logic signed [wbd_pkg::ACC_W-1:0] acc_new;
  logic [wbd_pkg::WACC_W-1:0] wacc_new;
  always_comb begin
    acc_new = (first_r ? '0 : acc_rd_r) + wbd_pkg::ACC_W'(prod_r);
    wacc_new = (first_r ? '0 : wacc_rd_r) + wbd_pkg::WACC_W'(w_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && in_ready && active) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   if (!last_r || job_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign job_valid = (state_r == ST_WR) && last_r;
  assign job.acc = acc_new;
  assign job.wacc = wacc_new;
  assign job.idx = idx_r;
  assign job.done = done_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      acc_rd_r <= acc_mem[slot_r];
      wacc_rd_r <= wacc_mem[slot_r];
    end
    if (state_r == ST_WR && state_nxt == ST_IDLE) begin
      acc_mem[slot_r] <= acc_new;
      wacc_mem[slot_r] <= wacc_new;
    end
  end

  logic [WEIGHT_BITS-1:0] w_in;
  assign w_in = mass_weighting ? in_density : WEIGHT_BITS'(1);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod_r <= PRW'(in_value) * PRW'($signed({1'b0, w_in}));
      w_r <= w_in;
      first_r <= (sx_r == '0) && (sy_r == '0) && (sz_r == '0);
      last_r <= (sx_r == f - 1'b1) && (sy_r == f - 1'b1) && (sz_r == f - 1'b1);
      done_r <= (gx_r == d - 1'b1) && (gy_r == d - 1'b1) && (gz_r == d - 1'b1);
      slot_r <= row_base_r + AW'(gx_r);
      idx_r <= plane_base_r + wbd_pkg::IDX_W'(row_base_r) + wbd_pkg::IDX_W'(gx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // position walk; group coords and bases advance incrementally
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      px_r <= '0; py_r <= '0; pz_r <= '0;
      gx_r <= '0; gy_r <= '0; gz_r <= '0;
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      row_base_r <= '0; plane_base_r <= '0;
    end else if (in_valid && in_ready) begin
      if (px_r + 1'b1 >= e) begin
        px_r <= '0; gx_r <= '0; sx_r <= '0;
        if (py_r + 1'b1 >= e) begin
          py_r <= '0; gy_r <= '0; sy_r <= '0; row_base_r <= '0;
          if (pz_r + 1'b1 >= e) begin
            pz_r <= '0; gz_r <= '0; sz_r <= '0; plane_base_r <= '0;
          end else begin
            pz_r <= pz_r + 1'b1;
            if (sz_r == f - 1'b1) begin
              sz_r <= '0; gz_r <= gz_r + 1'b1;
              plane_base_r <= plane_base_r
                              + wbd_pkg::IDX_W'(d) * wbd_pkg::IDX_W'(d);
            end else sz_r <= sz_r + 1'b1;
          end
        end else begin
          py_r <= py_r + 1'b1;
          if (sy_r == f - 1'b1) begin
            sy_r <= '0; gy_r <= gy_r + 1'b1; row_base_r <= row_base_r + AW'(d);
          end else sy_r <= sy_r + 1'b1;
        end
      end else begin
        px_r <= px_r + 1'b1;
        if (sx_r == f - 1'b1) begin
          sx_r <= '0; gx_r <= gx_r + 1'b1;
        end else sx_r <= sx_r + 1'b1;
      end
    end
  end
endmodule

>>> design/wbd_queue.sv
// Two-entry job queue between front and back ends.
module wbd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  wbd_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output wbd_pkg::job_t rd_job
);
  wbd_pkg::job_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_job = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

>>> design/wbd_back.sv
// Back end: restoring signed divide, one quotient bit a cycle, output register.
module wbd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  wbd_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [wbd_pkg::VAL_W-1:0]  out_mean,
  output logic [wbd_pkg::IDX_W-1:0]  out_idx,
  output logic          out_zero,
  output logic          out_done
);
  localparam int AW = wbd_pkg::ACC_W;
  localparam int WW = wbd_pkg::WACC_W;
  localparam int CW = $clog2(AW + 1);

  logic busy_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] num_r, quo_r;
  logic [WW:0]   rem_r;
  logic [WW-1:0] den_r;
  logic          neg_r, zero_r, done_r;
  logic [wbd_pkg::IDX_W-1:0] idx_r;

  // final quotient captured in the cycle after busy ends
  logic fin_r;

  // a new job waits until the output register has been taken
  assign job_ready = !busy_r && !out_valid && !fin_r;

  logic [WW:0] trial;
  logic [WW+1:0] diff;
  always_comb begin
    trial = {rem_r[WW-1:0], num_r[AW-1]};
    diff = {1'b0, trial} - {2'b00, den_r};
  end

  logic [AW-1:0] q_signed;
  assign q_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      num_r <= job.acc[AW-1] ? (~job.acc + 1'b1) : job.acc;
      neg_r <= job.acc[AW-1];
      den_r <= job.wacc;
      zero_r <= (job.wacc == '0);
      rem_r <= '0;
      quo_r <= '0;
      idx_r <= job.idx;
      done_r <= job.done;
      cnt_r <= CW'(AW);
    end else if (busy_r) begin
      num_r <= num_r << 1;
      if (!diff[WW+1]) begin
        rem_r <= diff[WW:0];
        quo_r <= {quo_r[AW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        quo_r <= {quo_r[AW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
    if (busy_r && cnt_r == CW'(1)) begin
      out_idx <= idx_r;
      out_zero <= zero_r;
      out_done <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_r) out_mean <= zero_r ? '0 : q_signed[wbd_pkg::VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; out_valid <= 1'b0; fin_r <= 1'b0;
    end else begin
      fin_r <= busy_r && cnt_r == CW'(1);
      if (job_valid && job_ready) busy_r <= 1'b1;
      else if (busy_r && cnt_r == CW'(1)) busy_r <= 1'b0;
      if (fin_r) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule

>>> design/weighted_block_downsample_3d.sv
// Weighted 3-D block downsampler.
// Usage: cells of a cubic block stream in on in_* in raster order (x fastest,
// then y, then z); in_tdata carries the signed value and the density. The
// block tracks position itself; each group of factor^3 cells is accumulated
// in a slab memory and, on its last cell, a divide job is queued.
// out_tdata carries mean and output index; out_tuser is the zero-weight flag
// and out_tlast marks the last output cell of the block.
// Flow: a cell inside the downsampled cube passes the front end's accept,
// memory-read and read-modify-write states, and no new cell is taken until
// it is written; a cell outside it is only accepted. Per result the back end
// runs the bit-serial divider, loads the quotient, waits for the output beat
// to be taken and only then takes the next job. A two-entry queue lets the
// front keep taking cells while the divider runs.
// Reset (rst_n low, synchronous) restores factor 2, edge 16, volume mode and
// position 0; accumulators are undefined until each group's first cell.
// Any cfg write restarts at position 0. After reset or a cfg write in_tready
// stays low while edge/factor is worked out. When the
// receiver stalls, results hold in the output register and the queue fills,
// then in_tready drops.
module weighted_block_downsample_3d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [wbd_pkg::VALUE_BITS+wbd_pkg::WEIGHT_BITS-1:0] in_tdata, // sample_value, density
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // mean_value, out_index, pad
  output logic        out_tuser, // zero_weight
  output logic        out_tlast  // block_done
);
  localparam int VALUE_BITS = wbd_pkg::VALUE_BITS;
  localparam int WEIGHT_BITS = wbd_pkg::WEIGHT_BITS;

  logic [3:0] factor_r;
  logic [5:0] edge_r;
  logic       mass_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= 4'd2; edge_r <= 6'd16; mass_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wbd_pkg::REG_FACTOR: factor_r <= cfg_data[3:0];
        wbd_pkg::REG_EDGE:   edge_r <= cfg_data;
        wbd_pkg::REG_MASS:   mass_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  wbd_pkg::job_t fj, bj;

  wbd_front u_front (
    .clk, .rst_n, .restart(cfg_we),
    .factor(factor_r), .block_edge(edge_r), .mass_weighting(mass_r),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_value(in_tdata[VALUE_BITS-1:0]),
    .in_density(in_tdata[VALUE_BITS+WEIGHT_BITS-1:VALUE_BITS]),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  wbd_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  logic [wbd_pkg::VAL_W-1:0] mean;
  logic [wbd_pkg::IDX_W-1:0] idx;
  wbd_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_mean(mean), .out_idx(idx), .out_zero(out_tuser), .out_done(out_tlast)
  );

  assign out_tdata = {1'b0, idx, mean};
endmodule
